[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every rising clock edge outside reset
`define C128_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("c128 assertion failed");

// consequent must hold at the clock after the antecedent
`define C128_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c128 assertion failed");

`endif

[hw/rtl/c128_pkg.sv]
// ----------------------------------------------------------------------------
// c128_pkg
// shared types, constants and the symbol pattern table
// ----------------------------------------------------------------------------
package c128_pkg;

   localparam logic [6:0] SYM_START   = 7'd104;
   localparam logic [6:0] SYM_STOP    = 7'd106;
   localparam logic [6:0] CHECK_MOD   = 7'd103;
   localparam logic [6:0] CHECK_INIT  = 7'd1;    // start value 104 reduced mod 103
   localparam logic [6:0] POS_LAST    = 7'd102;
   localparam logic [7:0] CHAR_OFFSET = 8'd32;
   localparam logic [7:0] CHAR_HIGH   = 8'd138;  // offset plus 106

   localparam logic [3:0] LEN_SYMBOL  = 4'd11;
   localparam logic [3:0] LEN_STOP    = 4'd13;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_CHECK  = 2'd2;
   localparam logic [1:0] KIND_STOP   = 2'd3;

   // one classified character, as handed from front to back
   typedef struct packed {
      logic       has_start;
      logic       has_data;
      logic       has_end;
      logic       err;
      logic [6:0] data_val;
      logic [6:0] check_val;
   } job_type;

   function automatic logic [12:0] c128_pattern(input logic [6:0] v);
      logic [12:0] p;
      case (v)
         7'd0:   p = 13'b11011001100;
         7'd1:   p = 13'b11001101100;
         7'd2:   p = 13'b11001100110;
         7'd3:   p = 13'b10010011000;
         7'd4:   p = 13'b10010001100;
         7'd5:   p = 13'b10001001100;
         7'd6:   p = 13'b10011001000;
         7'd7:   p = 13'b10011000100;
         7'd8:   p = 13'b10001100100;
         7'd9:   p = 13'b11001001000;
         7'd10:  p = 13'b11001000100;
         7'd11:  p = 13'b11000100100;
         7'd12:  p = 13'b10110011100;
         7'd13:  p = 13'b10011011100;
         7'd14:  p = 13'b10011001110;
         7'd15:  p = 13'b10111001100;
         7'd16:  p = 13'b10011101100;
         7'd17:  p = 13'b10011100110;
         7'd18:  p = 13'b11001110010;
         7'd19:  p = 13'b11001011100;
         7'd20:  p = 13'b11001001110;
         7'd21:  p = 13'b11011100100;
         7'd22:  p = 13'b11001110100;
         7'd23:  p = 13'b11101101110;
         7'd24:  p = 13'b11101001100;
         7'd25:  p = 13'b11100101100;
         7'd26:  p = 13'b11100100110;
         7'd27:  p = 13'b11101100100;
         7'd28:  p = 13'b11100110100;
         7'd29:  p = 13'b11100110010;
         7'd30:  p = 13'b11011011000;
         7'd31:  p = 13'b11011000110;
         7'd32:  p = 13'b11000110110;
         7'd33:  p = 13'b10100011000;
         7'd34:  p = 13'b10001011000;
         7'd35:  p = 13'b10001000110;
         7'd36:  p = 13'b10110001000;
         7'd37:  p = 13'b10001101000;
         7'd38:  p = 13'b10001100010;
         7'd39:  p = 13'b11010001000;
         7'd40:  p = 13'b11000101000;
         7'd41:  p = 13'b11000100010;
         7'd42:  p = 13'b10110111000;
         7'd43:  p = 13'b10110001110;
         7'd44:  p = 13'b10001101110;
         7'd45:  p = 13'b10111011000;
         7'd46:  p = 13'b10111000110;
         7'd47:  p = 13'b10001110110;
         7'd48:  p = 13'b11101110110;
         7'd49:  p = 13'b11010001110;
         7'd50:  p = 13'b11000101110;
         7'd51:  p = 13'b11011101000;
         7'd52:  p = 13'b11011100010;
         7'd53:  p = 13'b11011101110;
         7'd54:  p = 13'b11101011000;
         7'd55:  p = 13'b11101000110;
         7'd56:  p = 13'b11100010110;
         7'd57:  p = 13'b11101101000;
         7'd58:  p = 13'b11101100010;
         7'd59:  p = 13'b11100011010;
         7'd60:  p = 13'b11101111010;
         7'd61:  p = 13'b11001000010;
         7'd62:  p = 13'b11110001010;
         7'd63:  p = 13'b10100110000;
         7'd64:  p = 13'b10100001100;
         7'd65:  p = 13'b10010110000;
         7'd66:  p = 13'b10010000110;
         7'd67:  p = 13'b10000101100;
         7'd68:  p = 13'b10000100110;
         7'd69:  p = 13'b10110010000;
         7'd70:  p = 13'b10110000100;
         7'd71:  p = 13'b10011010000;
         7'd72:  p = 13'b10011000010;
         7'd73:  p = 13'b10000110100;
         7'd74:  p = 13'b10000110010;
         7'd75:  p = 13'b11000010010;
         7'd76:  p = 13'b11001010000;
         7'd77:  p = 13'b11110111010;
         7'd78:  p = 13'b11000010100;
         7'd79:  p = 13'b10001111010;
         7'd80:  p = 13'b10100111100;
         7'd81:  p = 13'b10010111100;
         7'd82:  p = 13'b10010011110;
         7'd83:  p = 13'b10111100100;
         7'd84:  p = 13'b10011110100;
         7'd85:  p = 13'b10011110010;
         7'd86:  p = 13'b11110100100;
         7'd87:  p = 13'b11110010100;
         7'd88:  p = 13'b11110010010;
         7'd89:  p = 13'b11011011110;
         7'd90:  p = 13'b11011110110;
         7'd91:  p = 13'b11110110110;
         7'd92:  p = 13'b10101111000;
         7'd93:  p = 13'b10100011110;
         7'd94:  p = 13'b10001011110;
         7'd95:  p = 13'b10111101000;
         7'd96:  p = 13'b10111100010;
         7'd97:  p = 13'b11110101000;
         7'd98:  p = 13'b11110100010;
         7'd99:  p = 13'b10111011110;
         7'd100: p = 13'b10111101110;
         7'd101: p = 13'b11101011110;
         7'd102: p = 13'b11110101110;
         7'd103: p = 13'b11010000100;
         7'd104: p = 13'b11010010000;
         7'd105: p = 13'b11010011100;
         7'd106: p = 13'b1100011101011;
         default: p = 13'b11011001100;
      endcase
      return p;
   endfunction

endpackage

[hw/rtl/code128_symbol_encoder.sv]
// ----------------------------------------------------------------------------
// code128_symbol_encoder
// code 128 (subset b) symbol stream generator, one character per transaction
// ----------------------------------------------------------------------------
// usage
//   req channel: one message character per transaction, req_final_char
//   marks the last one of a message
//   rsp channel: one bar/space pattern per transaction, msb of the used length = first module;
//   start before the first character, one data symbol per valid character up
//   to the first invalid one, check and stop after the final character
//   rsp_last_of_run flags the last symbol caused by one request transaction
//   an accepted character passes the two check pipeline stages and the job
//   queue before its first symbol is loaded into the output register
//   throughput: one symbol per cycle from the output register while rsp_stall
//   is low; a character produces 0 to 4 symbols, and one that produces none
//   is not queued; the back end's single pattern lookup per cycle sets this rate
//   req_stall rises once the job queue plus the two check pipeline stages
//   hold QUEUE_DEPTH characters
//   reset clears message state, the check accumulator, the queue and the
//   output valid flag; no clearing pass is needed
//   when rsp_stall is high the shown symbol holds and the queue fills up
//   behind it, then req_stall backs up the sender
// ----------------------------------------------------------------------------
module code128_symbol_encoder import c128_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_final_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_pattern,
   output logic [3:0]  rsp_pattern_length,
   output logic [1:0]  rsp_symbol_kind,
   output logic        rsp_range_error,
   output logic        rsp_last_of_run
);

   localparam int LevelW = $clog2(QUEUE_DEPTH + 1);

   // front to queue
   logic              push;
   job_type           push_job;
   logic [LevelW-1:0] q_level;

   // queue to back
   job_type           head_job;
   logic              head_valid;
   logic              pop;

   // front: classifies characters, keeps position/error state and the
   // weighted check (multiply, fold mod 103, accumulate)
   c128_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LEVEL_W     (LevelW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_final_char (req_final_char),
      .q_level        (q_level),
      .push           (push),
      .push_job       (push_job)
   );

   // decouples the per-character front from the per-symbol back
   c128_job_fifo #(
      .DEPTH   (QUEUE_DEPTH),
      .LEVEL_W (LevelW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .level      (q_level)
   );

   // back: walks start/data/check/stop of the head job, pattern lookup,
   // registered output
   c128_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .head_valid         (head_valid),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pattern        (rsp_pattern),
      .rsp_pattern_length (rsp_pattern_length),
      .rsp_symbol_kind    (rsp_symbol_kind),
      .rsp_range_error    (rsp_range_error),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

[hw/rtl/c128_front.sv]
// ----------------------------------------------------------------------------
// c128_front
// accepts characters, tracks message state and folds the weighted check
// ----------------------------------------------------------------------------
module c128_front import c128_pkg::*; #(
   parameter int QUEUE_DEPTH = 4,
   parameter int LEVEL_W     = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_final_char,
   input  logic [LEVEL_W-1:0] q_level,
   output logic               push,
   output job_type            push_job
);

   logic        in_msg_ff, in_msg_in;
   logic [6:0]  pos_ff, pos_in;
   logic        err_ff, err_in;
   logic        s1_v_ff, s1_v_in;
   job_type     s1_job_ff, s1_job_in;
   logic [13:0] s1_prod_ff, s1_prod_in;
   logic        s2_v_ff;
   job_type     s2_job_ff;
   logic [6:0]  s2_rem_ff, s2_rem_in;
   logic [6:0]  acc_ff, acc_in;

   logic [LEVEL_W:0] occupancy;
   logic        accept;
   logic        char_ok;
   logic        emit_data;
   logic        err_now;
   logic [7:0]  char_off;
   logic [11:0] fold1;
   logic [9:0]  fold2;
   logic [7:0]  fold3;
   logic [7:0]  acc_sum;
   logic [6:0]  acc_red;

   // queue slots are reserved at accept time, so the pipe never stalls
   assign occupancy = (LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(s1_v_ff)
                    + (LEVEL_W + 1)'(s2_v_ff);
   assign req_stall = occupancy >= (LEVEL_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign char_ok   = (req_character >= CHAR_OFFSET) && (req_character <= CHAR_HIGH);
   assign char_off  = req_character - CHAR_OFFSET;
   assign emit_data = char_ok && !err_ff;
   assign err_now   = err_ff || !char_ok;

   always_comb begin
      in_msg_in = in_msg_ff;
      pos_in    = pos_ff;
      err_in    = err_ff;
      if (accept) begin
         if (req_final_char) begin
            in_msg_in = 1'b0;
            pos_in    = 7'd1;
            err_in    = 1'b0;
         end else begin
            in_msg_in = 1'b1;
            err_in    = err_now;
            if (emit_data) begin
               pos_in = (pos_ff == POS_LAST) ? 7'd0 : pos_ff + 7'd1;
            end
         end
      end
   end

   always_comb begin
      s1_v_in             = accept;
      s1_job_in.has_start = !in_msg_ff;
      s1_job_in.has_data  = emit_data;
      s1_job_in.has_end   = req_final_char;
      s1_job_in.err       = err_now;
      s1_job_in.data_val  = char_off[6:0];
      s1_job_in.check_val = '0;
      s1_prod_in          = emit_data ? 14'(char_off[6:0]) * 14'(pos_ff) : '0;
   end

   // product mod 103 by folding: 128 is 25 mod 103
   always_comb begin
      fold1 = (12'(s1_prod_ff[13:7]) << 4) + (12'(s1_prod_ff[13:7]) << 3)
            + 12'(s1_prod_ff[13:7]) + 12'(s1_prod_ff[6:0]);
      fold2 = (10'(fold1[11:7]) << 4) + (10'(fold1[11:7]) << 3)
            + 10'(fold1[11:7]) + 10'(fold1[6:0]);
      fold3 = (8'(fold2[9:7]) << 4) + (8'(fold2[9:7]) << 3)
            + 8'(fold2[9:7]) + 8'(fold2[6:0]);
      if (fold3 >= 8'(2 * CHECK_MOD)) begin
         s2_rem_in = 7'(fold3 - 8'(2 * CHECK_MOD));
      end else if (fold3 >= 8'(CHECK_MOD)) begin
         s2_rem_in = 7'(fold3 - 8'(CHECK_MOD));
      end else begin
         s2_rem_in = fold3[6:0];
      end
   end

   // running check, one add and reduce per character
   always_comb begin
      acc_sum = 8'(acc_ff) + 8'(s2_rem_ff);
      acc_red = (acc_sum >= 8'(CHECK_MOD)) ? 7'(acc_sum - 8'(CHECK_MOD)) : acc_sum[6:0];
      acc_in  = acc_ff;
      if (s2_v_ff) begin
         acc_in = s2_job_ff.has_end ? CHECK_INIT : acc_red;
      end
   end

   always_comb begin
      push_job           = s2_job_ff;
      push_job.check_val = acc_red;
      push = s2_v_ff && (s2_job_ff.has_start || s2_job_ff.has_data || s2_job_ff.has_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         pos_ff    <= 7'd1;
         err_ff    <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         acc_ff    <= CHECK_INIT;
      end else begin
         in_msg_ff <= in_msg_in;
         pos_ff    <= pos_in;
         err_ff    <= err_in;
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s1_v_ff;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff  <= s1_job_in;
      s1_prod_ff <= s1_prod_in;
      s2_job_ff  <= s1_job_ff;
      s2_rem_ff  <= s2_rem_in;
   end

endmodule

[hw/rtl/c128_job_fifo.sv]
// ----------------------------------------------------------------------------
// c128_job_fifo
// short queue of classified characters between front and back
// ----------------------------------------------------------------------------
module c128_job_fifo import c128_pkg::*; #(
   parameter int DEPTH   = 4,
   parameter int LEVEL_W = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  job_type            push_job,
   input  logic               pop,
   output job_type            head_job,
   output logic               head_valid,
   output logic [LEVEL_W-1:0] level
);

   localparam int PTR_W = $clog2(DEPTH);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   assign head_job   = slot_ff[rd_ptr_ff];
   assign head_valid = level_ff != '0;
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hw/rtl/c128_back.sv]
// ----------------------------------------------------------------------------
// c128_back
// expands one queued character into its symbols, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module c128_back import c128_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  job_type     head_job,
   input  logic        head_valid,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_pattern,
   output logic [3:0]  rsp_pattern_length,
   output logic [1:0]  rsp_symbol_kind,
   output logic        rsp_range_error,
   output logic        rsp_last_of_run
);

   logic [3:0]  done_ff, done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] pattern_ff;
   logic [3:0]  length_ff;
   logic [1:0]  kind_ff;
   logic        err_ff;
   logic        last_ff;

   logic [3:0]  wanted;
   logic [3:0]  pending;
   logic [3:0]  pick;
   logic        is_last;
   logic        advance;
   logic        fire;
   logic [1:0]  kind;
   logic [6:0]  value;

   // symbol order: start, data, check, stop
   assign wanted  = {head_job.has_end, head_job.has_end, head_job.has_data,
                     head_job.has_start};
   assign pending = wanted & ~done_ff;
   assign pick    = pending & (~pending + 4'd1);
   assign is_last = (pending & ~pick) == 4'd0;
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = head_valid && advance;
   assign pop     = fire && is_last;

   always_comb begin
      case (pick)
         4'b0001: kind = KIND_START;
         4'b0010: kind = KIND_DATA;
         4'b0100: kind = KIND_CHECK;
         4'b1000: kind = KIND_STOP;
         default: kind = KIND_START;
      endcase
      case (kind)
         KIND_START: value = SYM_START;
         KIND_DATA:  value = head_job.data_val;
         KIND_CHECK: value = head_job.check_val;
         KIND_STOP:  value = SYM_STOP;
         default:    value = SYM_START;
      endcase
   end

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         done_in = is_last ? 4'd0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // the length follows the symbol value, so a data character of value 106
   // also comes out 13 modules wide
   always_ff @(posedge clock) begin
      if (fire) begin
         pattern_ff <= c128_pattern(value);
         length_ff  <= (value == SYM_STOP) ? LEN_STOP : LEN_SYMBOL;
         kind_ff    <= kind;
         err_ff     <= head_job.err;
         last_ff    <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pattern        = pattern_ff;
   assign rsp_pattern_length = length_ff;
   assign rsp_symbol_kind    = kind_ff;
   assign rsp_range_error    = err_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

[hw/rtl/c128_checker.sv]
// ----------------------------------------------------------------------------
// c128_checker
// port-level checks on the symbol stream, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c128_checker import c128_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [12:0] rsp_pattern,
   input logic [3:0]  rsp_pattern_length,
   input logic [1:0]  rsp_symbol_kind,
   input logic        rsp_last_of_run
);

   logic show_stop;
   logic show_check;
   logic show_short;
   logic stop_ok;

   assign show_stop  = rsp_valid && (rsp_symbol_kind == KIND_STOP);
   assign show_check = rsp_valid && (rsp_symbol_kind == KIND_CHECK);
   assign show_short = rsp_valid && ((rsp_symbol_kind == KIND_START)
                                  || (rsp_symbol_kind == KIND_CHECK));
   assign stop_ok    = (rsp_pattern_length == LEN_STOP) && rsp_last_of_run
                    && (rsp_pattern == c128_pattern(SYM_STOP));

   // a held symbol stays offered
   `C128_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // stop is the 13-module symbol and always closes its transaction's run
   `C128_ASSERT_ALWAYS(a_stop_shape, clock, reset, !show_stop || stop_ok)

   // start and check symbols are 11 modules wide
   `C128_ASSERT_ALWAYS(a_symbol_len, clock, reset, !show_short || rsp_pattern_length == LEN_SYMBOL)

   // a check symbol never closes its run: stop follows it in the same run
   `C128_ASSERT_ALWAYS(a_check_not_last, clock, reset, !show_check || !rsp_last_of_run)

endmodule

bind code128_symbol_encoder c128_checker u_c128_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_pattern        (rsp_pattern),
   .rsp_pattern_length (rsp_pattern_length),
   .rsp_symbol_kind    (rsp_symbol_kind),
   .rsp_last_of_run    (rsp_last_of_run)
);

[verif/tb_code128_symbol_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_code128_symbol_encoder
// self-checking bench for the code 128 symbol stream generator: a directed
// table of characters (lone messages, range errors, suppression) followed by
// random messages under four idling phases, every symbol checked in order
// against the table's own symbols or a cycle-free predictor of start, data, check and stop symbols
// ----------------------------------------------------------------------------
module tb_code128_symbol_encoder;
   import c128_pkg::*;

   // check accumulator value after reset and after each stop symbol
   localparam logic [6:0] CHECK_SEED    = 7'd104;
   localparam int         RAND_PER_PHASE = 125;
   localparam int         NUM_DIRECTED   = 21;
   localparam int         NUM_PHASES     = 4;

   // one symbol as seen on the rsp channel
   typedef struct packed {
      logic [12:0] pattern;
      logic [3:0]  len;
      logic [1:0]  kind;
      logic        err;
      logic        last;
   } symbol_type;

   // one character transaction; when typed is set, the symbols it must produce
   // are given here as symbol values and kinds instead of coming from the
   // predictor
   typedef struct packed {
      logic [7:0]      ch;
      logic            fin;
      logic            typed;
      logic [2:0]      n;
      logic [0:3][6:0] val;
      logic [0:3][1:0] kind;
      logic            err;
   } char_row_type;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character      = 8'd0;
   logic        req_final_char     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [12:0] rsp_pattern;
   logic [3:0]  rsp_pattern_length;
   logic [1:0]  rsp_symbol_kind;
   logic        rsp_range_error;
   logic        rsp_last_of_run;

   // bar/space module patterns, msb = first module of the used length
   logic [12:0] bar_table [0:106];

   // predictor state
   logic         msg_open;
   logic [6:0]   check_acc;
   logic [6:0]   next_pos;
   logic         bad_char_seen;
   symbol_type   pred_syms [0:3];

   symbol_type   expected_syms [$];
   char_row_type dir_table [0:NUM_DIRECTED-1];
   int           error_count    = 0;
   int           items_sent     = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;

   code128_symbol_encoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .req_final_char     (req_final_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pattern        (rsp_pattern),
      .rsp_pattern_length (rsp_pattern_length),
      .rsp_symbol_kind    (rsp_symbol_kind),
      .rsp_range_error    (rsp_range_error),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial bar_table = '{
      11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000,
      11'b10010001100, 11'b10001001100, 11'b10011001000, 11'b10011000100,
      11'b10001100100, 11'b11001001000, 11'b11001000100, 11'b11000100100,
      11'b10110011100, 11'b10011011100, 11'b10011001110, 11'b10111001100,
      11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
      11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110,
      11'b11101001100, 11'b11100101100, 11'b11100100110, 11'b11101100100,
      11'b11100110100, 11'b11100110010, 11'b11011011000, 11'b11011000110,
      11'b11000110110, 11'b10100011000, 11'b10001011000, 11'b10001000110,
      11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
      11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110,
      11'b10001101110, 11'b10111011000, 11'b10111000110, 11'b10001110110,
      11'b11101110110, 11'b11010001110, 11'b11000101110, 11'b11011101000,
      11'b11011100010, 11'b11011101110, 11'b11101011000, 11'b11101000110,
      11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
      11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000,
      11'b10100001100, 11'b10010110000, 11'b10010000110, 11'b10000101100,
      11'b10000100110, 11'b10110010000, 11'b10110000100, 11'b10011010000,
      11'b10011000010, 11'b10000110100, 11'b10000110010, 11'b11000010010,
      11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
      11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100,
      11'b10011110100, 11'b10011110010, 11'b11110100100, 11'b11110010100,
      11'b11110010010, 11'b11011011110, 11'b11011110110, 11'b11110110110,
      11'b10101111000, 11'b10100011110, 11'b10001011110, 11'b10111101000,
      11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
      11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100,
      11'b11010010000, 11'b11010011100, 13'b1100011101011
   };

   // one symbol from its value; only the stop value is 13 modules wide
   function automatic symbol_type make_symbol(input logic [6:0] v, input logic [1:0] k,
                                              input logic e);
      symbol_type s;
      s.pattern = bar_table[v];
      s.len     = (v == SYM_STOP) ? LEN_STOP : LEN_SYMBOL;
      s.kind    = k;
      s.err     = e;
      s.last    = 1'b0;
      return s;
   endfunction

   // advance the message state by one character, leaving the symbols it
   // produces in pred_syms; returns how many there are (0 to 4)
   function automatic int encode_char(input logic [7:0] ch, input logic fin);
      logic       in_range;
      logic       emit;
      logic [6:0] d;
      int         n;
      in_range = (ch >= CHAR_OFFSET) && (ch <= CHAR_HIGH);
      emit     = in_range && !bad_char_seen;
      n        = 0;
      // the error flag already covers the current character
      if (!in_range)
         bad_char_seen = 1'b1;
      if (!msg_open) begin
         pred_syms[n] = make_symbol(SYM_START, KIND_START, bad_char_seen);
         n++;
         msg_open = 1'b1;
      end
      // after an error, data symbols are dropped and stay out of the check
      if (emit) begin
         d = 7'(ch - CHAR_OFFSET);
         pred_syms[n] = make_symbol(d, KIND_DATA, bad_char_seen);
         n++;
         check_acc = 7'((int'(check_acc) + int'(d) * int'(next_pos)) % int'(CHECK_MOD));
         next_pos  = 7'((int'(next_pos) + 1) % int'(CHECK_MOD));
      end
      if (fin) begin
         pred_syms[n] = make_symbol(check_acc % CHECK_MOD, KIND_CHECK, bad_char_seen);
         n++;
         pred_syms[n] = make_symbol(SYM_STOP, KIND_STOP, bad_char_seen);
         n++;
         msg_open      = 1'b0;
         check_acc     = CHECK_SEED;
         next_pos      = 7'd1;
         bad_char_seen = 1'b0;
      end
      if (n > 0)
         pred_syms[n-1].last = 1'b1;
      return n;
   endfunction

   // drive one character transaction, then queue up the symbols it must yield
   task automatic send_char(input char_row_type row);
      symbol_type s;
      int         n;
      // random idle gap; valid drops only when a gap is taken
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_character  <= row.ch;
      req_final_char <= row.fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
      n = encode_char(row.ch, row.fin);
      if (row.typed) begin
         for (int i = 0; i < int'(row.n); i++) begin
            s      = make_symbol(row.val[i], row.kind[i], row.err);
            s.last = (i == int'(row.n) - 1);
            expected_syms.push_back(s);
         end
      end else begin
         for (int i = 0; i < n; i++)
            expected_syms.push_back(pred_syms[i]);
      end
   endtask

   // rsp side: random stall and in-order check of every accepted symbol
   always @(posedge clock) begin : rsp_monitor
      symbol_type want;
      symbol_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pattern, rsp_pattern_length, rsp_symbol_kind,
                   rsp_range_error, rsp_last_of_run};
            if (expected_syms.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected symbol: pattern %b len %0d kind %0d err %b last %b",
                           got.pattern, got.len, got.kind, got.err, got.last);
               error_count++;
            end else begin
               want = expected_syms.pop_front();
               if (got !== want) begin
                  if (error_count < 10) begin
                     $display("symbol mismatch at %0t", $realtime);
                     $display("  expected: pattern %b len %0d kind %0d err %b last %b",
                              want.pattern, want.len, want.kind, want.err, want.last);
                     $display("  actual:   pattern %b len %0d kind %0d err %b last %b",
                              got.pattern, got.len, got.kind, got.err, got.last);
                  end
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin : stimulus
      int           send_pcts [0:NUM_PHASES-1];
      int           recv_pcts [0:NUM_PHASES-1];
      int           msg_count;
      int           msg_len;
      int           phase_end;
      logic         noisy;
      char_row_type row;

      send_pcts = '{0, 75, 0, 33};
      recv_pcts = '{0, 0, 75, 33};
      msg_count = 0;

      // lone lowest character: value 0, check (104 + 0) mod 103 = 1
      dir_table[0]  = {8'd32, 1'b1, 1'b1, 3'd4, {SYM_START, 7'd0, 7'd1, SYM_STOP},
                       {KIND_START, KIND_DATA, KIND_CHECK, KIND_STOP}, 1'b0};
      // lone highest character: value 106 uses the 13-module bars, check 4
      dir_table[1]  = {8'd138, 1'b1, 1'b1, 3'd4, {SYM_START, 7'd106, 7'd4, SYM_STOP},
                       {KIND_START, KIND_DATA, KIND_CHECK, KIND_STOP}, 1'b0};
      // lone bad character: no data, empty check
      dir_table[2]  = {8'd0, 1'b1, 1'b1, 3'd3, {SYM_START, 7'd1, SYM_STOP, 7'd0},
                       {KIND_START, KIND_CHECK, KIND_STOP, KIND_START}, 1'b1};
      // bad first character opens the message with the error already set
      dir_table[3]  = {8'd255, 1'b0, 1'b1, 3'd1, {SYM_START, 21'd0},
                       {KIND_START, 6'd0}, 1'b1};
      // good character after the error is suppressed, nothing comes out
      dir_table[4]  = {8'd65, 1'b0, 1'b1, 3'd0, 28'd0, 8'd0, 1'b1};
      // closing the suppressed message still gives check and stop
      dir_table[5]  = {8'd66, 1'b1, 1'b1, 3'd2, {7'd1, SYM_STOP, 14'd0},
                       {KIND_CHECK, KIND_STOP, 4'd0}, 1'b1};
      // just below the range
      dir_table[6]  = {8'd31, 1'b0, 1'b1, 3'd1, {SYM_START, 21'd0},
                       {KIND_START, 6'd0}, 1'b1};
      // just above the range, as the final character
      dir_table[7]  = {8'd139, 1'b1, 1'b1, 3'd2, {7'd1, SYM_STOP, 14'd0},
                       {KIND_CHECK, KIND_STOP, 4'd0}, 1'b1};
      // a plain word
      dir_table[8]  = {8'd72,  1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[9]  = {8'd101, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[10] = {8'd108, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[11] = {8'd108, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[12] = {8'd111, 1'b1, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      // top of the range, then an error mid-message that yields nothing
      dir_table[13] = {8'd126, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[14] = {8'd127, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[15] = {8'd33,  1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[16] = {8'd137, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[17] = {8'd138, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[18] = {8'd200, 1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[19] = {8'd50,  1'b0, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};
      dir_table[20] = {8'd32,  1'b1, 1'b0, 3'd0, 28'd0, 8'd0, 1'b0};

      // predictor starts from the reset state
      msg_open      = 1'b0;
      check_acc     = CHECK_SEED;
      next_pos      = 7'd1;
      bad_char_seen = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling on either side
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_char(dir_table[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // sender holds off until the pipe is empty before changing pace
         req_valid <= 1'b0;
         while (expected_syms.size() != 0) @(posedge clock);
         @(posedge clock);
         send_idle_pct  = send_pcts[p];
         recv_stall_pct = recv_pcts[p];
         phase_end      = items_sent + RAND_PER_PHASE;
         while (items_sent < phase_end) begin
            // mostly short messages; now and then one long enough to wrap
            // the position counter
            if (msg_count == 3 || $urandom_range(59) == 0)
               msg_len = $urandom_range(104, 130);
            else
               msg_len = $urandom_range(1, 8);
            // a noisy message is heavy with bad characters and may run on
            // into the next one without a final flag
            noisy = ($urandom_range(9) == 0);
            msg_count++;
            for (int i = 0; i < msg_len; i++) begin
               row     = '0;
               row.fin = (i == msg_len - 1) && !(noisy && $urandom_range(1) == 0);
               // long messages stay clean so every data symbol enters the
               // check and the position really wraps
               if (msg_len <= 8 && $urandom_range(noisy ? 3 : 39) == 0)
                  row.ch = 8'($urandom_range(255));
               else
                  row.ch = 8'($urandom_range(138, 32));
               send_char(row);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_syms.size() != 0) @(posedge clock);
      // let any stray symbol show up
      repeat (20) @(posedge clock);

      if (error_count == 0 && expected_syms.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[code128_symbol_encoder.f]
+incdir+hw/rtl
hw/rtl/c128_pkg.sv
hw/rtl/c128_front.sv
hw/rtl/c128_job_fifo.sv
hw/rtl/c128_back.sv
hw/rtl/code128_symbol_encoder.sv
hw/rtl/c128_checker.sv
verif/tb_code128_symbol_encoder.sv
